@@ hdl/bgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, constants and glyph tables of the bitmap text glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

   localparam int ROW_PITCH_DEFAULT = 320;
   localparam int GLYPH_ROWS        = 7;
   localparam int GLYPH_COUNT       = 95;
   localparam int GI_W              = $clog2(GLYPH_COUNT);
   localparam int ROW_W             = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam int COL_W             = 3;
   localparam int WID_W             = 4;
   localparam int CSR_IDX_W         = 8;

   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam logic [7:0] LAST_CODE  = 8'd126;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = CSR_IDX_W'(1);

   localparam logic [7:0] FG_RESET = 8'd15;
   localparam logic [7:0] BG_RESET = 8'd0;

   typedef logic [0:GLYPH_ROWS-1][7:0] glyph_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic flush;
   } ctrl_type;

   typedef struct packed {
      logic code_ok;
      logic write_en;
      logic col_last;
      logic row_last;
      logic pend_valid;
      logic out_free;
   } stat_type;

   localparam glyph_type GLYPH_ROM [GLYPH_COUNT] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h80,8'h80,8'h80,8'h80,8'h00,8'h80,8'h00},
      '{8'hA0,8'hA0,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h48,8'hFC,8'h48,8'h48,8'hFC,8'h48,8'h00},
      '{8'h40,8'h60,8'h80,8'h40,8'h20,8'hC0,8'h40},
      '{8'hC4,8'hC8,8'h10,8'h20,8'h4C,8'h8C,8'h00},
      '{8'h40,8'hA0,8'h40,8'hA4,8'h90,8'h64,8'h00},
      '{8'hC0,8'h40,8'h80,8'h00,8'h00,8'h00,8'h00},
      '{8'h20,8'h40,8'h80,8'h80,8'h40,8'h20,8'h00},
      '{8'h80,8'h40,8'h20,8'h20,8'h40,8'h80,8'h00},
      '{8'h00,8'h90,8'h60,8'hF0,8'h60,8'h90,8'h00},
      '{8'h00,8'h00,8'h40,8'hE0,8'h40,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h40,8'h80},
      '{8'h00,8'h00,8'h00,8'hE0,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,8'h00},
      '{8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h00},
      '{8'h60,8'h90,8'hB0,8'hD0,8'h90,8'h60,8'h00},
      '{8'h40,8'hC0,8'h40,8'h40,8'h40,8'hE0,8'h00},
      '{8'h60,8'h90,8'h10,8'h60,8'h80,8'hF0,8'h00},
      '{8'hE0,8'h10,8'h60,8'h10,8'h10,8'hE0,8'h00},
      '{8'h20,8'hA0,8'hA0,8'hF0,8'h20,8'h20,8'h00},
      '{8'hF0,8'h80,8'hE0,8'h10,8'h10,8'hE0,8'h00},
      '{8'h70,8'h80,8'hE0,8'h90,8'h90,8'h60,8'h00},
      '{8'hF0,8'h10,8'h20,8'h40,8'h40,8'h40,8'h00},
      '{8'h60,8'h90,8'h60,8'h90,8'h90,8'h60,8'h00},
      '{8'h60,8'h90,8'h90,8'h70,8'h10,8'hE0,8'h00},
      '{8'h00,8'h80,8'h00,8'h00,8'h80,8'h00,8'h00},
      '{8'h00,8'h40,8'h00,8'h00,8'h40,8'h80,8'h00},
      '{8'h00,8'h20,8'h40,8'h80,8'h40,8'h20,8'h00},
      '{8'h00,8'hE0,8'h00,8'h00,8'hE0,8'h00,8'h00},
      '{8'h00,8'h80,8'h40,8'h20,8'h40,8'h80,8'h00},
      '{8'h60,8'h90,8'h10,8'h60,8'h00,8'h40,8'h00},
      '{8'h70,8'h88,8'hB8,8'hB0,8'h84,8'h78,8'h00},
      '{8'h60,8'h90,8'h90,8'hF0,8'h90,8'h90,8'h00},
      '{8'hE0,8'h90,8'hE0,8'h90,8'h90,8'hE0,8'h00},
      '{8'h60,8'h90,8'h80,8'h80,8'h90,8'h60,8'h00},
      '{8'hE0,8'h90,8'h90,8'h90,8'h90,8'hE0,8'h00},
      '{8'hF0,8'h80,8'hE0,8'h80,8'h80,8'hF0,8'h00},
      '{8'hF0,8'h80,8'hE0,8'h80,8'h80,8'h80,8'h00},
      '{8'h60,8'h90,8'h80,8'hB0,8'h90,8'h60,8'h00},
      '{8'h90,8'h90,8'hF0,8'h90,8'h90,8'h90,8'h00},
      '{8'hE0,8'h40,8'h40,8'h40,8'h40,8'hE0,8'h00},
      '{8'h70,8'h20,8'h20,8'h20,8'hA0,8'h40,8'h00},
      '{8'h90,8'hA0,8'hC0,8'hA0,8'h90,8'h90,8'h00},
      '{8'h80,8'h80,8'h80,8'h80,8'h80,8'hF0,8'h00},
      '{8'h88,8'hD8,8'hA8,8'h88,8'h88,8'h88,8'h00},
      '{8'h90,8'hD0,8'hB0,8'h90,8'h90,8'h90,8'h00},
      '{8'h60,8'h90,8'h90,8'h90,8'h90,8'h60,8'h00},
      '{8'hE0,8'h90,8'h90,8'hE0,8'h80,8'h80,8'h00},
      '{8'h70,8'h88,8'h88,8'h88,8'h90,8'h68,8'h00},
      '{8'hE0,8'h90,8'h90,8'hE0,8'h90,8'h90,8'h00},
      '{8'h70,8'h80,8'h60,8'h10,8'h10,8'hE0,8'h00},
      '{8'hE0,8'h40,8'h40,8'h40,8'h40,8'h40,8'h00},
      '{8'h90,8'h90,8'h90,8'h90,8'h90,8'h60,8'h00},
      '{8'h88,8'h88,8'h88,8'h88,8'h50,8'h20,8'h00},
      '{8'h88,8'h88,8'h88,8'hA8,8'hD8,8'h88,8'h00},
      '{8'h88,8'h50,8'h20,8'h50,8'h88,8'h88,8'h00},
      '{8'h88,8'h88,8'h50,8'h20,8'h20,8'h20,8'h00},
      '{8'hF0,8'h10,8'h20,8'h40,8'h80,8'hF0,8'h00},
      '{8'hE0,8'h80,8'h80,8'h80,8'h80,8'hE0,8'h00},
      '{8'h80,8'h40,8'h20,8'h10,8'h08,8'h04,8'h00},
      '{8'hE0,8'h20,8'h20,8'h20,8'h20,8'hE0,8'h00},
      '{8'h40,8'hA0,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'hF0,8'h00},
      '{8'hC0,8'h80,8'h40,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h00,8'h70,8'h90,8'h90,8'h70,8'h00},
      '{8'h80,8'h80,8'hE0,8'h90,8'h90,8'hE0,8'h00},
      '{8'h00,8'h00,8'h70,8'h80,8'h80,8'h70,8'h00},
      '{8'h10,8'h10,8'h70,8'h90,8'h90,8'h70,8'h00},
      '{8'h00,8'h00,8'h70,8'hA0,8'hC0,8'h70,8'h00},
      '{8'h30,8'h40,8'hE0,8'h40,8'h40,8'h40,8'h00},
      '{8'h00,8'h00,8'h60,8'h90,8'h70,8'h10,8'hE0},
      '{8'h80,8'h80,8'hE0,8'h90,8'h90,8'h90,8'h00},
      '{8'h00,8'h80,8'h00,8'h80,8'h80,8'h80,8'h00},
      '{8'h00,8'h20,8'h00,8'h20,8'h20,8'h20,8'hC0},
      '{8'h80,8'h80,8'hA0,8'hC0,8'hA0,8'h90,8'h00},
      '{8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00},
      '{8'h00,8'h00,8'hD0,8'hA8,8'hA8,8'hA8,8'h00},
      '{8'h00,8'h00,8'hE0,8'h90,8'h90,8'h90,8'h00},
      '{8'h00,8'h00,8'h60,8'h90,8'h90,8'h60,8'h00},
      '{8'h00,8'h00,8'hE0,8'h90,8'h90,8'hE0,8'h80},
      '{8'h00,8'h00,8'h70,8'h90,8'h90,8'h70,8'h10},
      '{8'h00,8'h00,8'h60,8'h80,8'h80,8'h80,8'h00},
      '{8'h00,8'h00,8'h70,8'hC0,8'h30,8'hE0,8'h00},
      '{8'h00,8'h40,8'hE0,8'h40,8'h40,8'h40,8'h00},
      '{8'h00,8'h00,8'h90,8'h90,8'h90,8'h70,8'h00},
      '{8'h00,8'h00,8'h88,8'h88,8'h50,8'h20,8'h00},
      '{8'h00,8'h00,8'hA8,8'hA8,8'hA8,8'h58,8'h00},
      '{8'h00,8'h00,8'h90,8'h60,8'h60,8'h90,8'h00},
      '{8'h00,8'h00,8'h90,8'h90,8'h70,8'h10,8'hE0},
      '{8'h00,8'h00,8'hF0,8'h20,8'h40,8'hF0,8'h00},
      '{8'h10,8'h20,8'h20,8'hC0,8'h20,8'h20,8'h10},
      '{8'h80,8'h80,8'h00,8'h80,8'h80,8'h00,8'h00},
      '{8'h80,8'h40,8'h40,8'h30,8'h40,8'h40,8'h80},
      '{8'h64,8'h98,8'h00,8'h00,8'h00,8'h00,8'h00}
   };

   localparam logic [WID_W-1:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
      4'd5,4'd2,4'd4,4'd7,4'd4,4'd7,4'd6,4'd3,4'd4,4'd4,4'd5,4'd4,4'd3,4'd4,4'd2,4'd7,
      4'd5,4'd4,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,
      4'd2,4'd3,4'd5,4'd4,4'd5,4'd5,4'd7,
      4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd4,4'd5,4'd5,4'd5,4'd6,4'd5,4'd5,4'd5,
      4'd6,4'd5,4'd5,4'd4,4'd5,4'd6,4'd6,4'd6,4'd6,4'd5,
      4'd4,4'd7,4'd4,4'd4,4'd5,4'd3,
      4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd5,4'd2,4'd4,4'd5,4'd2,4'd6,4'd5,4'd5,4'd5,
      4'd5,4'd4,4'd5,4'd4,4'd5,4'd6,4'd6,4'd5,4'd5,4'd5,
      4'd5,4'd2,4'd5,4'd7
   };

   // true for codes that have a glyph
   function automatic logic code_drawn(input logic [7:0] code);
      logic [7:0] rel;
      rel = code - FIRST_CODE;
      return (code >= FIRST_CODE) && (code <= LAST_CODE)
             && ({1'b0, rel} < 9'(GLYPH_COUNT));
   endfunction

endpackage
`default_nettype wire

@@ hdl/bgr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_if
// Valid/ready channels of the glyph renderer: character items, pixel write
// items and register writes.
// ----------------------------------------------------------------------------
interface bgr_req_if
   import bgr_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic [8:0] start_x;
   logic [7:0] start_y;
   logic       restart_at_position;

   modport source (output valid, char_code, start_x, start_y, restart_at_position,
                   input ready);
   modport sink   (input valid, char_code, start_x, start_y, restart_at_position,
                   output ready);
endinterface

interface bgr_rsp_if
   import bgr_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [15:0] pixel_offset;
   logic [7:0]  pixel_color;
   logic        last_pixel;

   modport source (output valid, pixel_offset, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_offset, pixel_color, last_pixel, output ready);
endinterface

interface bgr_csr_if
   import bgr_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/bgr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_ctrl
// Sequencer of the glyph renderer: accepts a character, walks its pixels one
// per cycle unless the output holds it, and flushes the held last pixel write.
// ----------------------------------------------------------------------------
module bgr_ctrl
   import bgr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // undrawn codes are taken and dropped
            if (req_valid && stat.code_ok) begin
               ctrl.accept = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // hold while a new write would push the held one into a full output
            if (!(stat.write_en && stat.pend_valid && !stat.out_free)) begin
               ctrl.step = 1'b1;
               if (stat.col_last && stat.row_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) begin
               ctrl.flush = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/bgr_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_dpath
// Datapath of the glyph renderer: color registers, cursor, glyph row and
// offset counters, a held pixel write and the output register.
// ----------------------------------------------------------------------------
module bgr_dpath
   import bgr_pkg::*;
#(
   parameter int ROW_PITCH = ROW_PITCH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   bgr_req_if.sink       req_bus,
   bgr_rsp_if.source     rsp_bus,
   bgr_csr_if.sink       csr_bus,
   input  wire ctrl_type ctrl,
   output stat_type      stat
);

   logic [7:0]       fg_ff, bg_ff;
   logic [15:0]      cursor_col_ff, cursor_row_ff;
   glyph_type        glyph_ff;
   logic [WID_W-1:0] width_ff;
   logic [15:0]      row_base_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic             pend_valid_ff;
   logic [15:0]      pend_offset_ff;
   logic [7:0]       pend_color_ff;
   logic             out_valid_ff;
   logic [15:0]      out_offset_ff;
   logic [7:0]       out_color_ff;
   logic             out_last_ff;

   logic [GI_W-1:0]  glyph_idx;
   logic [7:0]       row_bits;
   logic             bit_on;
   logic [15:0]      pix_offset;
   logic [15:0]      base_in;
   logic [COL_W-1:0] col_end;
   logic             out_free;

   assign glyph_idx  = GI_W'(req_bus.char_code - FIRST_CODE);
   assign row_bits   = glyph_ff[row_ff];
   assign bit_on     = row_bits[3'd7 - col_ff];
   assign pix_offset = row_base_ff + 16'(col_ff);
   assign base_in    = 16'(cursor_row_ff * 16'(ROW_PITCH)) + cursor_col_ff;
   assign col_end    = COL_W'(width_ff - WID_W'(1));
   assign out_free   = !out_valid_ff || rsp_bus.ready;

   assign stat.code_ok    = code_drawn(req_bus.char_code);
   assign stat.write_en   = bit_on || (bg_ff != 8'd0);
   assign stat.col_last   = (col_ff == col_end);
   assign stat.row_last   = (row_ff == ROW_W'(GLYPH_ROWS - 1));
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_offset = out_offset_ff;
   assign rsp_bus.pixel_color  = out_color_ff;
   assign rsp_bus.last_pixel   = out_last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff         <= FG_RESET;
         bg_ff         <= BG_RESET;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_FG_COLOR: fg_ff <= csr_bus.data;
               CSR_BG_COLOR: bg_ff <= csr_bus.data;
               default: ;
            endcase
         end
         if (ctrl.accept && req_bus.restart_at_position) begin
            cursor_col_ff <= 16'(req_bus.start_x);
            cursor_row_ff <= 16'(req_bus.start_y);
         end
         if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (ctrl.load) begin
            pend_valid_ff <= 1'b0;
         end
         if (ctrl.step && stat.write_en) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) begin
               out_valid_ff <= 1'b1;
            end
         end
         if (ctrl.flush) begin
            cursor_col_ff <= cursor_col_ff + 16'(width_ff);
            if (pend_valid_ff) begin
               out_valid_ff  <= 1'b1;
               pend_valid_ff <= 1'b0;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         glyph_ff <= GLYPH_ROM[glyph_idx];
         width_ff <= GLYPH_WIDTH[glyph_idx];
      end
      if (ctrl.load) begin
         row_base_ff <= base_in;
         row_ff      <= '0;
         col_ff      <= '0;
      end
      if (ctrl.step) begin
         if (stat.write_en) begin
            pend_offset_ff <= pix_offset;
            pend_color_ff  <= bit_on ? fg_ff : bg_ff;
            // a newer write exists, so the held one is not the last
            if (pend_valid_ff) begin
               out_offset_ff <= pend_offset_ff;
               out_color_ff  <= pend_color_ff;
               out_last_ff   <= 1'b0;
            end
         end
         if (stat.col_last) begin
            col_ff      <= '0;
            row_ff      <= row_ff + ROW_W'(1);
            row_base_ff <= row_base_ff + 16'(ROW_PITCH);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
      if (ctrl.flush && pend_valid_ff) begin
         out_offset_ff <= pend_offset_ff;
         out_color_ff  <= pend_color_ff;
         out_last_ff   <= 1'b1;
      end
   end

endmodule
`default_nettype wire

@@ hdl/bitmap_text_glyph_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer
// Draws one character per item as pixel write items into a framebuffer.
// ----------------------------------------------------------------------------
// Items are taken only when idle; the first pixel write waits for a second write or the flush.
// A drawn character's pixel walk covers 7 rows of its width (2..7), one glyph pixel
// examined per cycle unless backpressure holds it; undrawn codes are taken and dropped.
// Output backpressure stalls the pixel walk only when the output is full.
// Reset (synchronous, active high): fg 15, bg 0, cursor at 0,0, outputs empty.
module bitmap_text_glyph_renderer
   import bgr_pkg::*;
#(
   parameter int ROW_PITCH = ROW_PITCH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   bgr_req_if.sink   req_bus,
   bgr_rsp_if.source rsp_bus,
   bgr_csr_if.sink   csr_bus
);

   ctrl_type ctrl;
   stat_type stat;

   bgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   bgr_dpath #(
      .ROW_PITCH (ROW_PITCH)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .ctrl    (ctrl),
      .stat    (stat)
   );

endmodule
`default_nettype wire

@@ tb/tb_bitmap_text_glyph_renderer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_text_glyph_renderer
// Sends character items and palette register writes to the glyph renderer.
// An in-bench model predicts the pixel write items of untyped rows, typed rows
// carry their own expectation, and each result is compared in order. A short
// directed table comes first, then random text runs under several palette settings, with idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_text_glyph_renderer;
   import bgr_pkg::*;

   localparam int PITCH        = ROW_PITCH_DEFAULT;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 38;
   localparam int MAX_REPORTS  = 10;

   // register indexes that the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = CSR_IDX_W'(255);

   typedef enum logic [1:0] {
      ROW_CHAR,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [7:0]           code;
      logic [8:0]           x;
      logic [7:0]           y;
      logic                 restart;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [7:0]           reg_data;
      logic                 typed;      // expectation written in the row
      logic                 exp_some;   // typed row yields one pixel write
      logic [15:0]          exp_offset;
      logic [7:0]           exp_color;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] offset;
      logic [7:0]  color;
      logic        last;
   } pixel_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bgr_req_if req_bus ();
   bgr_rsp_if rsp_bus ();
   bgr_csr_if csr_bus ();

   bitmap_text_glyph_renderer #(
      .ROW_PITCH(PITCH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #2 clock = ~clock;

   // model state
   logic [7:0]      pal_fg  = FG_RESET;
   logic [7:0]      pal_bg  = BG_RESET;
   logic [15:0]     pen_col = '0;
   logic [15:0]     pen_row = '0;
   pixel_write_type pixel_writes [$];

   int  error_count = 0;
   int  rx_stall    = 0;
   bit  tx_quiet    = 1'b0;
   bit  rx_quiet    = 1'b0;

   stim_row_type directed_rows [$];

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // Walk the glyph as the block does; append pixel writes when keep is set.
   task automatic render_char(input logic [7:0] code, input logic [8:0] x,
                              input logic [7:0] y, input logic restart, input bit keep);
      int              gi;
      int              w;
      int              base;
      int              n;
      logic [7:0]      bits;
      logic            on;
      pixel_write_type px;
      if ((code < FIRST_CODE) || (code > LAST_CODE)) begin
         return;
      end
      gi = int'(code) - int'(FIRST_CODE);
      if (restart) begin
         pen_col = 16'(x);
         pen_row = 16'(y);
      end
      w    = int'(GLYPH_WIDTH[gi]);
      base = int'(pen_row) * PITCH + int'(pen_col);
      n    = 0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         bits = GLYPH_ROM[gi][r];
         for (int c = 0; c < w; c++) begin
            on = bits[7 - c];
            if (on || (pal_bg != 8'd0)) begin
               px.offset = 16'(base + r * PITCH + c);
               px.color  = on ? pal_fg : pal_bg;
               px.last   = 1'b0;
               if (keep) begin
                  pixel_writes.push_back(px);
               end
               n++;
            end
         end
      end
      if (keep && (n > 0)) begin
         pixel_writes[pixel_writes.size() - 1].last = 1'b1;
      end
      pen_col = pen_col + 16'(w);
   endtask

   function automatic stim_row_type char_row(input logic [7:0] code, input int x,
                                             input int y, input bit restart);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_CHAR;
      row.code    = code;
      row.x       = 9'(x);
      row.y       = 8'(y);
      row.restart = restart;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] code, input int x,
                                              input int y, input bit restart,
                                              input bit some, input int offset,
                                              input int color);
      stim_row_type row;
      row            = char_row(code, x, y, restart);
      row.typed      = 1'b1;
      row.exp_some   = some;
      row.exp_offset = 16'(offset);
      row.exp_color  = 8'(color);
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [7:0] data);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_REG;
      row.reg_idx  = idx;
      row.reg_data = data;
      return row;
   endfunction

   // Drop valid and hold until every pending pixel write is out, then let the
   // block finish any glyph that draws nothing.
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      while (pixel_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      hold_until_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_FG_COLOR: pal_fg = data;
         CSR_BG_COLOR: pal_bg = data;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_char(input stim_row_type row);
      int              gap;
      pixel_write_type px;
      gap = tx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.char_code           <= row.code;
      req_bus.start_x             <= row.x;
      req_bus.start_y             <= row.y;
      req_bus.restart_at_position <= row.restart;
      do @(posedge clock); while (!req_bus.ready);
      render_char(row.code, row.x, row.y, row.restart, !row.typed);
      if (row.typed && row.exp_some) begin
         px.offset = row.exp_offset;
         px.color  = row.exp_color;
         px.last   = 1'b1;
         pixel_writes.push_back(px);
      end
   endtask

   // Result side: random stalls, in-order check against the pending writes.
   always @(posedge clock) begin : rsp_check
      pixel_write_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_writes.size() == 0) begin
            flag_error($sformatf("unexpected pixel write offset=%0d color=%0d last=%0b",
                                 rsp_bus.pixel_offset, rsp_bus.pixel_color,
                                 rsp_bus.last_pixel));
         end else begin
            want = pixel_writes.pop_front();
            if ((rsp_bus.pixel_offset !== want.offset) ||
                (rsp_bus.pixel_color !== want.color) ||
                (rsp_bus.last_pixel !== want.last)) begin
               flag_error({
                  $sformatf("pixel write mismatch: expected offset=%0d color=%0d last=%0b",
                            want.offset, want.color, want.last),
                  $sformatf(", got offset=%0d color=%0d last=%0b",
                            rsp_bus.pixel_offset, rsp_bus.pixel_color,
                            rsp_bus.last_pixel)});
            end
         end
         rx_stall = rx_quiet ? 0 : $urandom_range(0, 18);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      logic [7:0]   code;
      logic [7:0]   fg;
      logic [7:0]   bg;
      int           sent;
      int           run_len;
      int           roll;
      int           x;
      int           y;
      bit           restart;

      req_bus.valid               = 1'b0;
      req_bus.char_code           = '0;
      req_bus.start_x             = '0;
      req_bus.start_y             = '0;
      req_bus.restart_at_position = 1'b0;
      csr_bus.valid               = 1'b0;
      csr_bus.index               = '0;
      csr_bus.data                = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // '.' is a single pixel at row 5, width 2; ' ' has no set bit
      directed_rows = '{
         typed_row(8'h2E, 0, 0, 1'b1, 1'b1, 1600, 15),
         typed_row(8'h2E, 0, 0, 1'b0, 1'b1, 1602, 15),
         typed_row(8'h00, 100, 100, 1'b1, 1'b0, 0, 0),
         typed_row(8'h2E, 0, 0, 1'b0, 1'b1, 1604, 15),
         typed_row(8'h1F, 7, 9, 1'b0, 1'b0, 0, 0),
         typed_row(8'h7F, 200, 50, 1'b1, 1'b0, 0, 0),
         typed_row(8'hFF, 511, 255, 1'b1, 1'b0, 0, 0),
         typed_row(8'h20, 319, 199, 1'b1, 1'b0, 0, 0),
         typed_row(8'h2E, 0, 0, 1'b0, 1'b1, 68, 15),
         typed_row(8'h2E, 511, 255, 1'b1, 1'b1, 18175, 15),
         char_row(8'h7E, 0, 0, 1'b0),
         reg_row(CSR_FG_COLOR, 8'hFF),
         typed_row(8'h2E, 10, 10, 1'b1, 1'b1, 4810, 255),
         reg_row(CSR_UNUSED_LO, 8'h00),
         reg_row(CSR_UNUSED_HI, 8'h5A),
         typed_row(8'h2E, 0, 1, 1'b1, 1'b1, 1920, 255),
         reg_row(CSR_BG_COLOR, 8'h01),
         char_row(8'h20, 0, 0, 1'b1),
         char_row(8'h23, 0, 0, 1'b0),
         reg_row(CSR_FG_COLOR, 8'h00),
         char_row(8'h41, 0, 0, 1'b0),
         char_row(8'h40, 0, 0, 1'b0),
         reg_row(CSR_BG_COLOR, 8'hFF),
         char_row(8'h57, 319, 199, 1'b1),
         char_row(8'h21, 0, 0, 1'b1),
         reg_row(CSR_BG_COLOR, 8'h00),
         reg_row(CSR_FG_COLOR, 8'h0F),
         char_row(8'h5F, 0, 0, 1'b0),
         char_row(8'h67, 0, 0, 1'b0)
      };

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
         end else begin
            send_char(directed_rows[i]);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin fg = 8'($urandom); bg = 8'h00; end
            1:       begin fg = 8'hFF;        bg = 8'h00; end
            2:       begin fg = 8'h00;        bg = 8'hFF; end
            3:       begin fg = 8'($urandom); bg = 8'($urandom); end
            4:       begin fg = 8'h01;        bg = 8'h80; end
            5:       begin fg = 8'($urandom); bg = 8'h00; end
            6:       begin fg = 8'($urandom); bg = 8'($urandom) | 8'h01; end
            default: begin fg = 8'hAA;        bg = 8'h55; end
         endcase
         write_reg(CSR_FG_COLOR, fg);
         write_reg(CSR_BG_COLOR, bg);
         tx_quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
         rx_quiet = (phase == 1) || ($urandom_range(0, 3) == 0);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // mostly short words, now and then a long line of text
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
            for (int k = 0; (k < run_len) && (sent < PHASE_ITEMS); k++) begin
               code    = 8'($urandom_range(int'(FIRST_CODE), int'(LAST_CODE)));
               restart = (k == 0);
               x       = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 319);
               y       = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 199);
               roll    = $urandom_range(0, 99);
               if (roll < 6) begin
                  code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(127, 255));
               end else if (roll < 10) begin
                  restart = !restart;
               end
               row = char_row(code, x, y, restart);
               send_char(row);
               sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
               hold_until_drained();
            end
         end
      end

      hold_until_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
